### src/greenhouse_climate_controller_unit_assert.svh
// Assertion macros for the checker file of this block.
`ifndef GREENHOUSE_CLIMATE_CONTROLLER_UNIT_ASSERT_SVH
`define GREENHOUSE_CLIMATE_CONTROLLER_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define GCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define GCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/gcc_pkg.sv
`timescale 1ns / 1ps

package gcc_pkg;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_t;

    localparam int unsigned DWELL_MS = 30000;
    localparam int unsigned STALE_MS = 120000;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE           = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_TEMP_ON      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_TEMP_OFF     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_HUMIDITY_ON  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN_HUMIDITY_OFF = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FOG_HUMIDITY_ON  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FOG_HUMIDITY_OFF = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SCHEDULE_HOURS   = 3'd7;

    localparam logic        RST_ENABLE           = 1'b1;
    localparam logic [10:0] RST_FAN_TEMP_ON      = 11'd300;
    localparam logic [10:0] RST_FAN_TEMP_OFF     = 11'd270;
    localparam logic [9:0]  RST_FAN_HUMIDITY_ON  = 10'd850;
    localparam logic [9:0]  RST_FAN_HUMIDITY_OFF = 10'd750;
    localparam logic [9:0]  RST_FOG_HUMIDITY_ON  = 10'd500;
    localparam logic [9:0]  RST_FOG_HUMIDITY_OFF = 10'd650;
    localparam logic [39:0] RST_SCHEDULE_HOURS   = 40'd0;

    localparam int HOUR_W = 5;

    // Input item as packed on s_tdata; the last member sits in the lowest bits.
    typedef struct packed {
        logic              light_is_on;
        logic              fogger_is_on;
        logic              pump_is_on;
        logic              fan_is_on;
        logic [HOUR_W-1:0] current_hour;
        logic              clock_valid;
        logic [9:0]        humidity;
        logic [10:0]       temperature;
        logic              auto_mode;
        logic [31:0]       last_valid_read_ms;
        logic [31:0]       now_ms;
    } in_item_t;

    // Result item as packed on m_tdata, padded to two bytes.
    typedef struct packed {
        logic [6:0] pad;
        logic       safe_mode;
        cmd_t       light_cmd;
        cmd_t       fogger_cmd;
        cmd_t       pump_cmd;
        cmd_t       fan_cmd;
    } out_item_t;

endpackage

### src/gcc_window.sv
`timescale 1ns / 1ps

// Hour-of-day schedule window; the window wraps past midnight when on > off.
module gcc_window (
    input  logic [gcc_pkg::HOUR_W-1:0] on_hour,
    input  logic [gcc_pkg::HOUR_W-1:0] off_hour,
    input  logic [gcc_pkg::HOUR_W-1:0] hour,
    output logic                       active
);
    import gcc_pkg::*;

    always_comb begin
        if (on_hour == off_hour) begin
            active = 1'b0;
        end else if (on_hour < off_hour) begin
            active = (hour >= on_hour) && (hour < off_hour);
        end else begin
            active = (hour >= on_hour) || (hour < off_hour);
        end
    end

endmodule

### src/greenhouse_climate_controller_unit.sv
`timescale 1ns / 1ps

// Greenhouse climate controller.
// One control tick enters on the s_ channel: time, last valid sensor time,
// mode, sensor readings, hour of day and the present device states. Exactly
// one result leaves on the m_ channel: on/off commands for fan, pump, fogger
// and light, plus the safe-mode flag.
// The tick is captured in an input register and evaluated into the result
// register as soon as that is free or being emptied, and offered on m_.
// One tick per cycle is sustained while m_tready stays high; the dwell
// timers are updated when a tick moves into the result register, so the
// next tick already sees them.
// When the receiver holds m_tready low the result stays in place, the input
// register still takes one more tick, and then s_tready drops until the
// result is taken.
// The cfg_ channel writes the eight settings registers and is always ready;
// write them only while no tick is in flight.
// Reset (aresetn low, synchronous) empties both registers, clears the dwell
// timers and the safe flag, and loads the settings with their defaults.
module greenhouse_climate_controller_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // now_ms, last_valid_read_ms, auto_mode, temperature, humidity,
    // clock_valid, current_hour, fan_is_on, pump_is_on, fogger_is_on,
    // light_is_on
    input  logic [95:0]                        s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fan_cmd, pump_cmd, fogger_cmd, light_cmd, safe_mode, zero padding
    output logic [15:0]                        m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gcc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gcc_pkg::*;

    // Settings
    logic        enable_reg;
    logic [10:0] fan_temp_on_reg;
    logic [10:0] fan_temp_off_reg;
    logic [9:0]  fan_hum_on_reg;
    logic [9:0]  fan_hum_off_reg;
    logic [9:0]  fog_hum_on_reg;
    logic [9:0]  fog_hum_off_reg;
    logic [39:0] sched_reg;

    // Pipeline
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;

    // Controller state
    logic [TIME_BITS-1:0] fan_time_reg, fan_time_next;
    logic [TIME_BITS-1:0] pump_time_reg, pump_time_next;
    logic [TIME_BITS-1:0] fog_time_reg, fog_time_next;
    logic                 safe_reg, safe_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] read_t;
    logic                 active;
    logic                 stale;
    logic                 fan_may, pump_may, fog_may;
    logic                 fan_win, fog_win, pump_win, light_win;
    logic                 fan_sched, fog_sched;
    logic                 fan_on_cond, fan_off_cond;
    logic                 fog_on_cond, fog_off_cond;
    logic signed [10:0]   temp_s;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= RST_ENABLE;
            fan_temp_on_reg  <= RST_FAN_TEMP_ON;
            fan_temp_off_reg <= RST_FAN_TEMP_OFF;
            fan_hum_on_reg   <= RST_FAN_HUMIDITY_ON;
            fan_hum_off_reg  <= RST_FAN_HUMIDITY_OFF;
            fog_hum_on_reg   <= RST_FOG_HUMIDITY_ON;
            fog_hum_off_reg  <= RST_FOG_HUMIDITY_OFF;
            sched_reg        <= RST_SCHEDULE_HOURS;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLE:           enable_reg       <= cfg_data[0];
                REG_FAN_TEMP_ON:      fan_temp_on_reg  <= cfg_data[10:0];
                REG_FAN_TEMP_OFF:     fan_temp_off_reg <= cfg_data[10:0];
                REG_FAN_HUMIDITY_ON:  fan_hum_on_reg   <= cfg_data[9:0];
                REG_FAN_HUMIDITY_OFF: fan_hum_off_reg  <= cfg_data[9:0];
                REG_FOG_HUMIDITY_ON:  fog_hum_on_reg   <= cfg_data[9:0];
                REG_FOG_HUMIDITY_OFF: fog_hum_off_reg  <= cfg_data[9:0];
                REG_SCHEDULE_HOURS:   sched_reg        <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fan_time_reg  <= '0;
            pump_time_reg <= '0;
            fog_time_reg  <= '0;
            safe_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                fan_time_reg  <= fan_time_next;
                pump_time_reg <= pump_time_next;
                fog_time_reg  <= fog_time_next;
                safe_reg      <= safe_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item_t'(s_tdata);
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    // Schedule windows
    gcc_window u_fan_win (
        .on_hour  (sched_reg[4:0]),
        .off_hour (sched_reg[9:5]),
        .hour     (in_item_reg.current_hour),
        .active   (fan_win)
    );

    gcc_window u_fog_win (
        .on_hour  (sched_reg[14:10]),
        .off_hour (sched_reg[19:15]),
        .hour     (in_item_reg.current_hour),
        .active   (fog_win)
    );

    gcc_window u_pump_win (
        .on_hour  (sched_reg[24:20]),
        .off_hour (sched_reg[29:25]),
        .hour     (in_item_reg.current_hour),
        .active   (pump_win)
    );

    gcc_window u_light_win (
        .on_hour  (sched_reg[34:30]),
        .off_hour (sched_reg[39:35]),
        .hour     (in_item_reg.current_hour),
        .active   (light_win)
    );

    // Time values wrap modulo 2^TIME_BITS.
    assign now_t  = TIME_BITS'(in_item_reg.now_ms);
    assign read_t = TIME_BITS'(in_item_reg.last_valid_read_ms);
    assign temp_s = $signed(in_item_reg.temperature);

    assign active = enable_reg && in_item_reg.auto_mode;
    assign stale  = 64'(TIME_BITS'(now_t - read_t)) >= 64'(STALE_MS);

    // A change time of zero means the device was never switched.
    assign fan_may  = (fan_time_reg == '0) ||
                      (64'(TIME_BITS'(now_t - fan_time_reg)) >= 64'(DWELL_MS));
    assign pump_may = (pump_time_reg == '0) ||
                      (64'(TIME_BITS'(now_t - pump_time_reg)) >= 64'(DWELL_MS));
    assign fog_may  = (fog_time_reg == '0) ||
                      (64'(TIME_BITS'(now_t - fog_time_reg)) >= 64'(DWELL_MS));

    assign fan_sched    = in_item_reg.clock_valid && fan_win;
    assign fog_sched    = in_item_reg.clock_valid && fog_win;
    assign fan_on_cond  = (temp_s >= $signed(fan_temp_on_reg)) ||
                          (in_item_reg.humidity >= fan_hum_on_reg) || fan_sched;
    assign fan_off_cond = (temp_s <= $signed(fan_temp_off_reg)) &&
                          (in_item_reg.humidity <= fan_hum_off_reg) && !fan_sched;
    assign fog_on_cond  = (in_item_reg.humidity <= fog_hum_on_reg) || fog_sched;
    assign fog_off_cond = (in_item_reg.humidity >= fog_hum_off_reg) && !fog_sched;

    always_comb begin
        out_item_next  = '0;
        fan_time_next  = fan_time_reg;
        pump_time_next = pump_time_reg;
        fog_time_next  = fog_time_reg;
        safe_next      = safe_reg;

        if (active) begin
            safe_next = stale;
            if (stale) begin
                // Stale sensors: switch off the fan, pump and fogger if running, no dwell.
                if (in_item_reg.fan_is_on) begin
                    out_item_next.fan_cmd = CMD_OFF;
                    fan_time_next         = now_t;
                end
                if (in_item_reg.pump_is_on) begin
                    out_item_next.pump_cmd = CMD_OFF;
                    pump_time_next         = now_t;
                end
                if (in_item_reg.fogger_is_on) begin
                    out_item_next.fogger_cmd = CMD_OFF;
                    fog_time_next            = now_t;
                end
            end else begin
                if (fan_may) begin
                    if (fan_on_cond && !in_item_reg.fan_is_on) begin
                        out_item_next.fan_cmd = CMD_ON;
                        fan_time_next         = now_t;
                    end else if (fan_off_cond && in_item_reg.fan_is_on) begin
                        out_item_next.fan_cmd = CMD_OFF;
                        fan_time_next         = now_t;
                    end
                end
                if (fog_may) begin
                    if (fog_on_cond && !in_item_reg.fogger_is_on) begin
                        out_item_next.fogger_cmd = CMD_ON;
                        fog_time_next            = now_t;
                    end else if (fog_off_cond && in_item_reg.fogger_is_on) begin
                        out_item_next.fogger_cmd = CMD_OFF;
                        fog_time_next            = now_t;
                    end
                end
                if (in_item_reg.clock_valid && pump_may) begin
                    if (pump_win && !in_item_reg.pump_is_on) begin
                        out_item_next.pump_cmd = CMD_ON;
                        pump_time_next         = now_t;
                    end else if (!pump_win && in_item_reg.pump_is_on) begin
                        out_item_next.pump_cmd = CMD_OFF;
                        pump_time_next         = now_t;
                    end
                end
            end

            if (in_item_reg.clock_valid) begin
                if (light_win && !in_item_reg.light_is_on) begin
                    out_item_next.light_cmd = CMD_ON;
                end else if (!light_win && in_item_reg.light_is_on) begin
                    out_item_next.light_cmd = CMD_OFF;
                end
            end
        end

        out_item_next.safe_mode = safe_next;
    end

endmodule

### src/gcc_checker.sv
`timescale 1ns / 1ps
`include "greenhouse_climate_controller_unit_assert.svh"

module gcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import gcc_pkg::*;

    // A stalled result must not change under the receiver.
    `GCC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // No command field ever carries the unused code.
    `GCC_ASSERT(a_cmd_code, m_tvalid |-> m_tdata[1:0] != 2'b11 && m_tdata[3:2] != 2'b11 && m_tdata[5:4] != 2'b11 && m_tdata[7:6] != 2'b11, "undefined command code")

    // In safe mode the fan, pump and fogger are never switched on.
    `GCC_ASSERT(a_safe_no_on, m_tvalid && m_tdata[8] |-> m_tdata[1:0] != CMD_ON && m_tdata[3:2] != CMD_ON && m_tdata[5:4] != CMD_ON, "device switched on in safe mode")

    // An accepted tick must pass through the input register and show as m_tvalid.
    `GCC_ASSERT(a_in_reaches_out, s_tvalid && s_tready |=> ##1 m_tvalid, "accepted tick did not reach the result register")

    // Reset empties the pipeline.
    `GCC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

bind greenhouse_climate_controller_unit gcc_checker u_gcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/greenhouse_climate_controller_unit_tb.sv
`timescale 1ns / 1ps

module greenhouse_climate_controller_unit_tb;
    import gcc_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic               en;
        logic signed [10:0] ft_on;
        logic signed [10:0] ft_off;
        logic [9:0]         fh_on;
        logic [9:0]         fh_off;
        logic [9:0]         gh_on;
        logic [9:0]         gh_off;
        logic [39:0]        hours;
    } ctl_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [95:0]            s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    greenhouse_climate_controller_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Controller settings and state as the block should hold them.
    ctl_t        ctl;
    logic [31:0] fan_mark = '0;
    logic [31:0] pump_mark = '0;
    logic [31:0] fog_mark = '0;
    logic        safe_flag = 1'b0;

    // Greenhouse as seen by the stimulus: device states follow the commands.
    logic        plant_fan = 1'b0;
    logic        plant_pump = 1'b0;
    logic        plant_fog = 1'b0;
    logic        plant_light = 1'b0;
    logic [31:0] sim_now = '0;

    out_item_t   pending_decisions[$];
    int          bad_fields = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    function automatic logic [4:0] slot_hour(int k);
        return ctl.hours[5*k +: 5];
    endfunction

    function automatic logic in_window(logic [4:0] on, logic [4:0] off, logic [4:0] hour);
        if (on == off) return 1'b0;
        if (on < off) return hour >= on && hour < off;
        return hour >= on || hour < off;
    endfunction

    function automatic logic dwell_ok(logic [31:0] mark, logic [31:0] now);
        logic [31:0] since;
        since = now - mark;
        return mark == '0 || since >= DWELL_MS;
    endfunction

    // Works out the commands for one tick and advances the controller state.
    function automatic out_item_t decide_tick(in_item_t t);
        out_item_t          r;
        logic signed [10:0] temp;
        logic               fs, gs, f_on, f_off, g_on, g_off;
        logic [31:0]        stale;
        r = '0;
        temp = t.temperature;
        if (ctl.en && t.auto_mode) begin
            stale = t.now_ms - t.last_valid_read_ms;
            safe_flag = stale >= STALE_MS;
            if (safe_flag) begin
                if (t.fan_is_on) begin
                    r.fan_cmd = CMD_OFF;
                    fan_mark = t.now_ms;
                end
                if (t.pump_is_on) begin
                    r.pump_cmd = CMD_OFF;
                    pump_mark = t.now_ms;
                end
                if (t.fogger_is_on) begin
                    r.fogger_cmd = CMD_OFF;
                    fog_mark = t.now_ms;
                end
            end else begin
                fs = t.clock_valid && in_window(slot_hour(0), slot_hour(1), t.current_hour);
                f_on = temp >= ctl.ft_on || t.humidity >= ctl.fh_on || fs;
                f_off = temp <= ctl.ft_off && t.humidity <= ctl.fh_off && !fs;
                // The turn-on test is tried first but only applies to a fan that is off.
                if (f_on && !t.fan_is_on && dwell_ok(fan_mark, t.now_ms)) begin
                    r.fan_cmd = CMD_ON;
                    fan_mark = t.now_ms;
                end else if (f_off && t.fan_is_on && dwell_ok(fan_mark, t.now_ms)) begin
                    r.fan_cmd = CMD_OFF;
                    fan_mark = t.now_ms;
                end
                gs = t.clock_valid && in_window(slot_hour(2), slot_hour(3), t.current_hour);
                g_on = t.humidity <= ctl.gh_on || gs;
                g_off = t.humidity >= ctl.gh_off && !gs;
                if (g_on && !t.fogger_is_on && dwell_ok(fog_mark, t.now_ms)) begin
                    r.fogger_cmd = CMD_ON;
                    fog_mark = t.now_ms;
                end else if (g_off && t.fogger_is_on && dwell_ok(fog_mark, t.now_ms)) begin
                    r.fogger_cmd = CMD_OFF;
                    fog_mark = t.now_ms;
                end
                if (t.clock_valid) begin
                    if (in_window(slot_hour(4), slot_hour(5), t.current_hour)) begin
                        if (!t.pump_is_on && dwell_ok(pump_mark, t.now_ms)) begin
                            r.pump_cmd = CMD_ON;
                            pump_mark = t.now_ms;
                        end
                    end else if (t.pump_is_on && dwell_ok(pump_mark, t.now_ms)) begin
                        r.pump_cmd = CMD_OFF;
                        pump_mark = t.now_ms;
                    end
                end
            end
            if (t.clock_valid) begin
                if (in_window(slot_hour(6), slot_hour(7), t.current_hour)) begin
                    if (!t.light_is_on) r.light_cmd = CMD_ON;
                end else if (t.light_is_on) begin
                    r.light_cmd = CMD_OFF;
                end
            end
        end
        r.safe_mode = safe_flag;
        return r;
    endfunction

    function automatic void follow_cmd(cmd_t c, ref logic dev);
        if (c == CMD_ON) dev = 1'b1;
        else if (c == CMD_OFF) dev = 1'b0;
    endfunction

    function automatic in_item_t mk_tick(logic [31:0] now, logic [31:0] last, logic auto_on,
                                         int temp, int hum, logic clk_ok, int hour,
                                         logic f, logic p, logic g, logic l);
        in_item_t t;
        t.now_ms = now;
        t.last_valid_read_ms = last;
        t.auto_mode = auto_on;
        t.temperature = temp[10:0];
        t.humidity = hum[9:0];
        t.clock_valid = clk_ok;
        t.current_hour = hour[4:0];
        t.fan_is_on = f;
        t.pump_is_on = p;
        t.fogger_is_on = g;
        t.light_is_on = l;
        return t;
    endfunction

    // Mostly a plausible greenhouse: time moves forward, the devices follow
    // the commands, readings are fresh. The rest is stale data, time jumps,
    // out-of-range readings and devices that do not follow.
    function automatic in_item_t next_tick();
        in_item_t t;
        int       r;
        int       v;
        r = $urandom_range(0, 99);
        if (r < 70) sim_now += $urandom_range(0, 20000);
        else if (r < 85) sim_now += $urandom_range(29990, 30010);
        else if (r < 95) sim_now += $urandom_range(0, 200000);
        else if (r < 98) sim_now = $urandom();
        else sim_now = '0;
        t.now_ms = sim_now;
        r = $urandom_range(0, 99);
        if (r < 75) t.last_valid_read_ms = sim_now - $urandom_range(0, 5000);
        else if (r < 85) t.last_valid_read_ms = sim_now - $urandom_range(119990, 120010);
        else if (r < 95) t.last_valid_read_ms = sim_now - $urandom_range(120000, 400000);
        else t.last_valid_read_ms = $urandom();
        t.auto_mode = $urandom_range(0, 99) < 92;
        r = $urandom_range(0, 99);
        if (r < 75) v = int'($urandom_range(0, 1200)) - 400;
        else if (r < 85) v = int'(ctl.ft_on) + int'($urandom_range(0, 6)) - 3;
        else if (r < 93) v = int'(ctl.ft_off) + int'($urandom_range(0, 6)) - 3;
        else v = $urandom_range(0, 2047);
        t.temperature = v[10:0];
        r = $urandom_range(0, 99);
        if (r < 70) v = $urandom_range(0, 1000);
        else if (r < 78) v = int'(ctl.fh_on) + int'($urandom_range(0, 4)) - 2;
        else if (r < 84) v = int'(ctl.fh_off) + int'($urandom_range(0, 4)) - 2;
        else if (r < 90) v = int'(ctl.gh_on) + int'($urandom_range(0, 4)) - 2;
        else if (r < 95) v = int'(ctl.gh_off) + int'($urandom_range(0, 4)) - 2;
        else v = $urandom_range(0, 1023);
        t.humidity = v[9:0];
        t.clock_valid = $urandom_range(0, 99) < 85;
        t.current_hour = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, 23))
                                                       : 5'($urandom_range(0, 31));
        t.fan_is_on = plant_fan ^ ($urandom_range(0, 99) < 8);
        t.pump_is_on = plant_pump ^ ($urandom_range(0, 99) < 8);
        t.fogger_is_on = plant_fog ^ ($urandom_range(0, 99) < 8);
        t.light_is_on = plant_light ^ ($urandom_range(0, 99) < 8);
        return t;
    endfunction

    function automatic logic signed [10:0] rand_temp(bit wild);
        int picks[4] = '{-1024, 1023, -400, 800};
        int v;
        v = wild ? picks[$urandom_range(0, 3)] : int'($urandom_range(0, 1200)) - 400;
        return v[10:0];
    endfunction

    function automatic logic [9:0] rand_hum(bit wild);
        int picks[4] = '{0, 1023, 1000, 1};
        int v;
        v = wild ? picks[$urandom_range(0, 3)] : $urandom_range(0, 1000);
        return v[9:0];
    endfunction

    function automatic ctl_t rand_ctl(bit wild);
        ctl_t c;
        c.en = 1'b1;
        c.ft_on = rand_temp(wild);
        c.ft_off = rand_temp(wild);
        c.fh_on = rand_hum(wild);
        c.fh_off = rand_hum(wild);
        c.gh_on = rand_hum(wild);
        c.gh_off = rand_hum(wild);
        for (int k = 0; k < 8; k++) begin
            c.hours[5*k +: 5] = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23))
                                                              : 5'($urandom_range(0, 31));
        end
        return c;
    endfunction

    // Upper bits above a register's width are don't-care; fill them at random
    // half of the time.
    function automatic logic [39:0] with_junk(logic [39:0] v, int w);
        logic [63:0] j;
        j = {$urandom(), $urandom()};
        if ($urandom_range(0, 1)) return v | (j[39:0] << w);
        return v;
    endfunction

    task automatic cfg_put(logic [CFG_INDEX_W-1:0] idx, logic [39:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_ENABLE:           ctl.en = data[0];
            REG_FAN_TEMP_ON:      ctl.ft_on = data[10:0];
            REG_FAN_TEMP_OFF:     ctl.ft_off = data[10:0];
            REG_FAN_HUMIDITY_ON:  ctl.fh_on = data[9:0];
            REG_FAN_HUMIDITY_OFF: ctl.fh_off = data[9:0];
            REG_FOG_HUMIDITY_ON:  ctl.gh_on = data[9:0];
            REG_FOG_HUMIDITY_OFF: ctl.gh_off = data[9:0];
            REG_SCHEDULE_HOURS:   ctl.hours = data;
            default: ;
        endcase
    endtask

    task automatic program_all(ctl_t c);
        cfg_put(REG_ENABLE, with_junk({39'd0, c.en}, 1));
        cfg_put(REG_FAN_TEMP_ON, with_junk({29'd0, c.ft_on}, 11));
        cfg_put(REG_FAN_TEMP_OFF, with_junk({29'd0, c.ft_off}, 11));
        cfg_put(REG_FAN_HUMIDITY_ON, with_junk({30'd0, c.fh_on}, 10));
        cfg_put(REG_FAN_HUMIDITY_OFF, with_junk({30'd0, c.fh_off}, 10));
        cfg_put(REG_FOG_HUMIDITY_ON, with_junk({30'd0, c.gh_on}, 10));
        cfg_put(REG_FOG_HUMIDITY_OFF, with_junk({30'd0, c.gh_off}, 10));
        cfg_put(REG_SCHEDULE_HOURS, c.hours);
        cfg_valid <= 1'b0;
    endtask

    // Sends one tick; the commands are predicted when the transaction happens.
    task automatic push_tick(in_item_t t);
        out_item_t d;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        d = decide_tick(t);
        pending_decisions.push_back(d);
        follow_cmd(d.fan_cmd, plant_fan);
        follow_cmd(d.pump_cmd, plant_pump);
        follow_cmd(d.fogger_cmd, plant_fog);
        follow_cmd(d.light_cmd, plant_light);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic note_mismatch(string what, int want, int got);
        bad_fields++;
        if (bad_fields <= 10)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, what, want, got);
    endtask

    task automatic test_directed();
        ctl_t        c;
        logic [31:0] now;
        push_tick(mk_tick(1000, 1000, 0, 300, 400, 1, 10, 0, 0, 0, 0));
        push_tick(mk_tick(5000, 4000, 1, 300, 400, 1, 10, 0, 0, 0, 0));
        push_tick(mk_tick(10000, 9000, 1, 200, 700, 1, 10, 1, 0, 1, 0));
        // Exactly the dwell time after the previous change.
        push_tick(mk_tick(35000, 34000, 1, 200, 700, 1, 10, 1, 0, 1, 0));
        // A change at time zero is recorded as never changed.
        push_tick(mk_tick(0, 0, 1, 1023, 1023, 0, 31, 0, 0, 0, 1));
        push_tick(mk_tick(1, 0, 1, -1024, 0, 0, 0, 1, 0, 0, 0));
        push_tick(mk_tick(200000, 80000, 1, 250, 600, 1, 12, 1, 1, 1, 1));
        push_tick(mk_tick(200100, 80000, 0, 250, 600, 1, 12, 1, 1, 1, 1));
        push_tick(mk_tick(200200, 80201, 1, 250, 600, 1, 12, 0, 0, 0, 0));
        push_tick(mk_tick(100, 32'hFFFF_FF00, 1, 250, 600, 1, 12, 1, 1, 1, 1));
        push_tick(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 500, 900, 1, 23, 0, 0, 0, 0));
        settle();
        // Fan 22..6 across midnight, fogger never, pump 8..10, light 20..30.
        c = ctl;
        c.hours = {5'd30, 5'd20, 5'd10, 5'd8, 5'd5, 5'd5, 5'd6, 5'd22};
        program_all(c);
        now = 400000;
        push_tick(mk_tick(now, now - 1000, 1, 200, 700, 1, 23, 0, 0, 0, 0));
        now += 40000;
        push_tick(mk_tick(now, now - 1000, 1, 200, 700, 1, 9, 1, 0, 0, 0));
        now += 40000;
        push_tick(mk_tick(now, now - 1000, 1, 200, 700, 1, 27, 0, 1, 0, 0));
        now += 40000;
        push_tick(mk_tick(now, now - 1000, 1, 200, 700, 1, 31, 0, 0, 0, 1));
        now += 40000;
        push_tick(mk_tick(now, now - 1000, 1, 200, 700, 0, 3, 1, 1, 1, 1));
        settle();
        // Overlapping fan thresholds: both the on and the off test hold.
        c = ctl;
        c.ft_on = 11'sd100;
        c.ft_off = 11'sd200;
        program_all(c);
        now += 40000;
        push_tick(mk_tick(now, now - 1000, 1, 150, 700, 1, 12, 1, 0, 0, 0));
        now += 40000;
        push_tick(mk_tick(now, now - 1000, 1, 150, 700, 1, 12, 0, 0, 0, 0));
        settle();
    endtask

    task automatic test_disabled();
        ctl_t c;
        c = rand_ctl(1'b0);
        c.en = 1'b0;
        program_all(c);
        repeat (20) push_tick(next_tick());
        settle();
    endtask

    task automatic test_config_extremes();
        ctl_t c;
        c = rand_ctl(1'b1);
        c.ft_on = -11'sd1024;
        c.ft_off = 11'sd1023;
        c.fh_on = '0;
        c.fh_off = '0;
        c.gh_on = '0;
        c.gh_off = '0;
        c.hours = '1;
        program_all(c);
        repeat (100) push_tick(next_tick());
        settle();
        c.ft_on = 11'sd1023;
        c.ft_off = -11'sd1024;
        c.fh_on = '1;
        c.fh_off = '1;
        c.gh_on = '1;
        c.gh_off = '1;
        c.hours = '0;
        program_all(c);
        repeat (100) push_tick(next_tick());
        settle();
        program_all(rand_ctl(1'b1));
        repeat (100) push_tick(next_tick());
        settle();
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 4; ph++) begin
            program_all(rand_ctl(ph == 3));
            repeat (130) push_tick(next_tick());
            settle();
        end
    endtask

    // The receiver stops for a long stretch while ticks keep coming, so the
    // pipeline fills and the input side has to stall.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        program_all(rand_ctl(1'b0));
        holds_asked++;
        repeat (60) push_tick(next_tick());
        settle();
        send_idle_pct = saved_idle;
    endtask

    always @(posedge aclk) begin : result_side
        out_item_t want;
        out_item_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_decisions.size() == 0) begin
                    note_mismatch("result with nothing pending, data", 0, int'(m_tdata));
                end else begin
                    want = pending_decisions.pop_front();
                    if (got.fan_cmd !== want.fan_cmd)
                        note_mismatch("fan_cmd", want.fan_cmd, got.fan_cmd);
                    if (got.pump_cmd !== want.pump_cmd)
                        note_mismatch("pump_cmd", want.pump_cmd, got.pump_cmd);
                    if (got.fogger_cmd !== want.fogger_cmd)
                        note_mismatch("fogger_cmd", want.fogger_cmd, got.fogger_cmd);
                    if (got.light_cmd !== want.light_cmd)
                        note_mismatch("light_cmd", want.light_cmd, got.light_cmd);
                    if (got.safe_mode !== want.safe_mode)
                        note_mismatch("safe_mode", want.safe_mode, got.safe_mode);
                    if (got.pad !== '0)
                        note_mismatch("padding", 0, got.pad);
                end
            end
            if (stall_left == 0 && holds_done != holds_asked) begin
                holds_done = holds_asked;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int send_pcts[3] = '{22, 73, 0};
        int recv_pcts[3] = '{73, 22, 0};
        ctl.en = RST_ENABLE;
        ctl.ft_on = RST_FAN_TEMP_ON;
        ctl.ft_off = RST_FAN_TEMP_OFF;
        ctl.fh_on = RST_FAN_HUMIDITY_ON;
        ctl.fh_off = RST_FAN_HUMIDITY_OFF;
        ctl.gh_on = RST_FOG_HUMIDITY_ON;
        ctl.gh_off = RST_FOG_HUMIDITY_OFF;
        ctl.hours = RST_SCHEDULE_HOURS;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_disabled();
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = send_pcts[mode];
            recv_idle_pct = recv_pcts[mode];
            if (mode == 0) test_config_extremes();
            test_random_mix();
            if (mode == 1) test_backpressure();
        end
        settle();
        if (bad_fields == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/gcc_pkg.sv
src/gcc_window.sv
src/greenhouse_climate_controller_unit.sv
src/gcc_checker.sv
test/greenhouse_climate_controller_unit_tb.sv
